[rtl/number_literal_parser_assert.svh]
// Assertion macros shared by the number literal parser RTL.
`ifndef NUMBER_LITERAL_PARSER_ASSERT_SVH
`define NUMBER_LITERAL_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define NLP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checked at every edge, during reset as well.
`define NLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define NLP_ASSERT(lbl, clk, rstn, prop, msg)
`define NLP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/nlp_pkg.sv]
// Types and constants of the number literal parser.
`timescale 1ns / 1ps

package nlp_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned FRAC_W  = 6;

    localparam logic [FRAC_W-1:0] FRAC_MAX = 6'd63;

    localparam logic [1:0] ST_INT  = 2'd0;
    localparam logic [1:0] ST_FRAC = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ZERO  = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_BIN = 2'd2,
        RX_OCT = 2'd3
    } radix_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } lex_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] value;
        logic [FRAC_W-1:0]  frac_digits;
    } lex_result_t;

    typedef struct packed {
        phase_t             phase;
        radix_t             radix;
        logic [VALUE_W-1:0] accum;
        logic               dot_seen;
        logic [FRAC_W-1:0]  frac_count;
        logic               bad;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        phase:      PH_START,
        radix:      RX_DEC,
        accum:      '0,
        dot_seen:   1'b0,
        frac_count: '0,
        bad:        1'b0
    };

endpackage

[rtl/nlp_in_stage.sv]
// Input register of the number literal parser.
`timescale 1ns / 1ps

module nlp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nlp_pkg::lex_item_t s_item,
    input  logic              pop,
    output logic              item_valid,
    output nlp_pkg::lex_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    nlp_pkg::lex_item_t item_reg;

    // The register refills in the same cycle that its character moves on.
    assign s_ready    = !valid_reg || pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (pop) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

[rtl/nlp_lexer.sv]
// Lexer state and the per-character update of the number literal parser.
`timescale 1ns / 1ps

module nlp_lexer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  nlp_pkg::lex_item_t   item,
    input  logic                 out_free,
    output logic                 pop,
    output logic                 res_valid,
    output nlp_pkg::lex_result_t res
);

    nlp_pkg::lex_state_t state_reg;
    nlp_pkg::lex_state_t state_next;

    // One body character in the base held by the state.
    function automatic nlp_pkg::lex_state_t body_char(nlp_pkg::lex_state_t s,
                                                      logic [7:0] c);
        nlp_pkg::lex_state_t r;
        r = s;
        if (!s.bad) begin
            case (s.radix)
                nlp_pkg::RX_HEX: begin
                    case (c) inside
                        ["0":"9"]:
                            r.accum = {s.accum[nlp_pkg::VALUE_W-5:0], c[3:0]};
                        ["a":"f"], ["A":"F"]:
                            r.accum = {s.accum[nlp_pkg::VALUE_W-5:0], 4'(c[3:0] + 4'd9)};
                        default:
                            r.bad = 1'b1;
                    endcase
                end
                nlp_pkg::RX_BIN: begin
                    case (c) inside
                        "0", "1": r.accum = {s.accum[nlp_pkg::VALUE_W-2:0], c[0]};
                        default:  r.bad = 1'b1;
                    endcase
                end
                nlp_pkg::RX_OCT: begin
                    case (c) inside
                        ["0":"7"]: r.accum = {s.accum[nlp_pkg::VALUE_W-4:0], c[2:0]};
                        default:   r.bad = 1'b1;
                    endcase
                end
                default: begin
                    case (c) inside
                        ["0":"9"]: begin
                            // Times ten as eight plus two, modulo 2^64.
                            r.accum = (s.accum << 3) + (s.accum << 1)
                                    + {{(nlp_pkg::VALUE_W-4){1'b0}}, c[3:0]};
                            if (s.dot_seen && (s.frac_count < nlp_pkg::FRAC_MAX)) begin
                                r.frac_count = 6'(s.frac_count + 6'd1);
                            end
                        end
                        ".": begin
                            if (s.dot_seen) begin
                                r.bad = 1'b1;
                            end else begin
                                r.dot_seen = 1'b1;
                            end
                        end
                        default: r.bad = 1'b1;
                    endcase
                end
            endcase
        end
        return r;
    endfunction

    // A final character waits while the result register is still occupied.
    assign pop       = item_valid && (!item.last || out_free);
    assign res_valid = pop && item.last;

    always_comb begin
        nlp_pkg::lex_state_t body_in;
        nlp_pkg::lex_state_t body_out;
        nlp_pkg::lex_state_t upd;
        logic                use_body;
        logic [7:0]          c;

        c        = item.ch;
        body_in  = state_reg;
        use_body = 1'b0;
        upd      = state_reg;

        case (state_reg.phase)
            nlp_pkg::PH_START: begin
                body_in.radix = nlp_pkg::RX_DEC;
                use_body      = (c != "0");
            end
            nlp_pkg::PH_ZERO: begin
                body_in.radix = nlp_pkg::RX_OCT;
                case (c) inside
                    ["0":"9"]: use_body = 1'b1;
                    default:   use_body = 1'b0;
                endcase
            end
            default: begin
                use_body = 1'b1;
            end
        endcase

        body_out = body_char(body_in, c);

        case (state_reg.phase)
            nlp_pkg::PH_START: begin
                if (c == "0") begin
                    upd.phase = nlp_pkg::PH_ZERO;
                    upd.radix = nlp_pkg::RX_DEC;
                end else begin
                    upd       = body_out;
                    upd.phase = nlp_pkg::PH_BODY;
                end
            end
            nlp_pkg::PH_ZERO: begin
                upd.phase = nlp_pkg::PH_BODY;
                case (c) inside
                    "x", "X": upd.radix = nlp_pkg::RX_HEX;
                    "b", "B": upd.radix = nlp_pkg::RX_BIN;
                    "o", "O": upd.radix = nlp_pkg::RX_OCT;
                    ["0":"9"]: begin
                        upd       = body_out;
                        upd.phase = nlp_pkg::PH_BODY;
                    end
                    ".": begin
                        upd.radix    = nlp_pkg::RX_DEC;
                        upd.accum    = '0;
                        upd.dot_seen = 1'b1;
                    end
                    default: upd.bad = 1'b1;
                endcase
            end
            default: begin
                if (use_body) begin
                    upd = body_out;
                end
            end
        endcase

        // Result of a final character.
        if (state_reg.phase == nlp_pkg::PH_START) begin
            res.status      = nlp_pkg::ST_INT;
            res.value       = {{(nlp_pkg::VALUE_W-8){1'b0}}, c} - 64'd48;
            res.frac_digits = '0;
        end else if (upd.bad) begin
            res.status      = nlp_pkg::ST_BAD;
            res.value       = '0;
            res.frac_digits = '0;
        end else if ((upd.radix == nlp_pkg::RX_DEC) && upd.dot_seen) begin
            res.status      = nlp_pkg::ST_FRAC;
            res.value       = upd.accum;
            res.frac_digits = upd.frac_count;
        end else begin
            res.status      = nlp_pkg::ST_INT;
            res.value       = upd.accum;
            res.frac_digits = '0;
        end

        if (!pop) begin
            state_next = state_reg;
        end else if (item.last) begin
            state_next = nlp_pkg::LEX_RESET;
        end else begin
            state_next = upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nlp_pkg::LEX_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/nlp_out_stage.sv]
// Result register of the number literal parser.
`timescale 1ns / 1ps

module nlp_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_valid,
    input  nlp_pkg::lex_result_t res,
    output logic                 out_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output nlp_pkg::lex_result_t m_res
);

    logic                 valid_reg;
    logic                 valid_next;
    nlp_pkg::lex_result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

[rtl/number_literal_parser.sv]
// Top level of the number literal parser: input register, lexer and result register.
`timescale 1ns / 1ps
`include "number_literal_parser_assert.svh"

// The block reads a numeric literal one character per request on the s_ channel,
// with s_last set on the final character, and returns one result request on the
// m_ channel for each literal: status, value modulo 2^64 and fraction digit count.
// Hex, binary and octal prefixes, leading-zero octal and decimal with one dot are
// recognised; a malformed literal gives status 2 with value and count zero, but a
// one-character literal is taken as a decimal digit unchecked and a bare prefix
// gives zero. Each accepted character is held in an input register and passes
// from there through the lexer update (a constant multiply-add or shift on the
// 64-bit accumulator) into the lexer state and, for a final character, into the
// result register. Throughput is one character per cycle while no final character
// waits for the result register, and a new literal may follow directly behind the
// final character of the previous one.
// When the receiver stalls, the result stays in the result register and further
// characters are still accepted; only a final character waits in the input
// register until the result register is free, and s_ready drops behind it.
// Reset is synchronous and active low; it empties both registers and returns the
// lexer to the start of a literal.
module number_literal_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_value,
    output logic [5:0]  m_frac_digits
);

    nlp_pkg::lex_item_t   s_item;
    nlp_pkg::lex_item_t   item;
    nlp_pkg::lex_result_t res;
    nlp_pkg::lex_result_t m_res;
    logic                 item_valid;
    logic                 pop;
    logic                 res_valid;
    logic                 out_free;

    assign s_item.ch   = s_ch;
    assign s_item.last = s_last;

    nlp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    nlp_lexer u_lexer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .pop        (pop),
        .res_valid  (res_valid),
        .res        (res)
    );

    nlp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_status      = m_res.status;
    assign m_value       = m_res.value;
    assign m_frac_digits = m_res.frac_digits;

    // A result is loaded only into a free result register.
    `NLP_ASSERT(a_load_free, aclk, aresetn, res_valid |-> (!m_valid || m_ready), "result overwritten")
    // A malformed literal carries neither value nor fraction digits.
    `NLP_ASSERT(a_bad_zero, aclk, aresetn, (m_valid && (m_status == nlp_pkg::ST_BAD)) |-> ((m_value == 64'd0) && (m_frac_digits == 6'd0)), "malformed result not cleared")
    // An integer result has no fraction digits.
    `NLP_ASSERT(a_int_nofrac, aclk, aresetn, (m_valid && (m_status == nlp_pkg::ST_INT)) |-> (m_frac_digits == 6'd0), "integer result with fraction digits")
    // Reset empties the result register.
    `NLP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule
